// ===== rtl/seqnum_sorted_packet_buffer_macros.svh =====
// Assertion macros for the sorted packet buffer.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SEQNUM_SORTED_PACKET_BUFFER_MACROS_SVH
`define SEQNUM_SORTED_PACKET_BUFFER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spb assertion failed (same cycle)");

// Next-cycle implication, checked out of reset.
`define SPB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spb assertion failed (next cycle)");

`endif

// ===== rtl/spb_pkg.sv =====
// Package for the sorted packet buffer: request and status codes, defaults,
// and the command and flag structs passed between the top level and the cells.
package spb_pkg;

    // Default sizing.
    localparam int SPB_DEPTH       = 32;
    localparam int SPB_SEQ_BITS    = 8;
    localparam int SPB_HANDLE_BITS = 16;

    // Fixed field widths.
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int MAXSZ_W  = 6;
    localparam int FILL_W   = 6;

    // Value of the limit register after reset.
    localparam logic [MAXSZ_W-1:0] MAXSZ_RESET = 6'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_POP    = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Per-cell command from the top level; at most one bit is set.
    typedef struct packed {
        logic ld_new;      // take the incoming entry
        logic shift_up;    // take the entry of the cell toward the head
        logic shift_down;  // take the entry of the cell toward the tail
    } spb_cell_cmd_t;

    // Per-cell compare flags against the incoming sequence number.
    typedef struct packed {
        logic ge;          // empty, or stored sequence is not smaller
        logic eq;          // occupied and stored sequence is equal
    } spb_cell_flag_t;

endpackage

// ===== rtl/spb_cell.sv =====
// One storage cell of the sorted packet buffer: occupancy, sequence and handle.
// Depends on spb_pkg for the command and flag structs.
module spb_cell
    import spb_pkg::*;
#(
    parameter int SEQ_BITS    = SPB_SEQ_BITS,
    parameter int HANDLE_BITS = SPB_HANDLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  spb_cell_cmd_t          cmd,
    input  logic [SEQ_BITS-1:0]    key_seq,
    input  logic [HANDLE_BITS-1:0] key_hnd,
    input  logic                   up_occ,
    input  logic [SEQ_BITS-1:0]    up_seq,
    input  logic [HANDLE_BITS-1:0] up_hnd,
    input  logic                   dn_occ,
    input  logic [SEQ_BITS-1:0]    dn_seq,
    input  logic [HANDLE_BITS-1:0] dn_hnd,
    output logic                   occ,
    output logic [SEQ_BITS-1:0]    seq,
    output logic [HANDLE_BITS-1:0] hnd,
    output spb_cell_flag_t         flag
);

    logic                   occ_reg, occ_next;
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;

    // Select the next content of the cell.
    always_comb begin
        occ_next = occ_reg;
        seq_next = seq_reg;
        hnd_next = hnd_reg;
        priority if (cmd.ld_new) begin
            occ_next = 1'b1;
            seq_next = key_seq;
            hnd_next = key_hnd;
        end else if (cmd.shift_up) begin
            occ_next = up_occ;
            seq_next = up_seq;
            hnd_next = up_hnd;
        end else if (cmd.shift_down) begin
            occ_next = dn_occ;
            seq_next = dn_seq;
            hnd_next = dn_hnd;
        end
    end

    // Occupancy is control state; the entry itself needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg <= seq_next;
        hnd_reg <= hnd_next;
    end

    // Compare the stored sequence with the incoming one.
    always_comb begin
        flag.ge = !occ_reg || (seq_reg >= key_seq);
        flag.eq = occ_reg && (seq_reg == key_seq);
    end

    assign occ = occ_reg;
    assign seq = seq_reg;
    assign hnd = hnd_reg;

endmodule

// ===== rtl/seqnum_sorted_packet_buffer.sv =====
// Channel  | Group        | Contents
// input    | s_t*         | tuser: req_type; tdata: seq_number, pkt_handle
// result   | m_t*         | tuser: status; tdata: out_seq_number, out_handle, fill_count
// config   | cfg_wr_*     | max_size, written when cfg_wr_en is high
//
// Each request is accepted, applied to the cell row and its result registered
// at the same clock edge, so one transfer per cycle while the result register
// is empty or being drained.
// Reset (aresetn low, synchronous) empties the buffer and sets max_size to 1.
// A stalled result holds the input only while the result register is full.
//
// Top level of the sorted packet buffer: a row of spb_cell instances.
// Depends on spb_pkg, spb_cell and the assertion macro header.
`include "seqnum_sorted_packet_buffer_macros.svh"

module seqnum_sorted_packet_buffer
    import spb_pkg::*;
#(
    parameter int DEPTH       = SPB_DEPTH,
    parameter int SEQ_BITS    = SPB_SEQ_BITS,
    parameter int HANDLE_BITS = SPB_HANDLE_BITS,
    localparam int TDATA_IN_W  = ((SEQ_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int TDATA_OUT_W = ((SEQ_BITS + HANDLE_BITS + FILL_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write.
    input  logic                   cfg_wr_en,
    input  logic [MAXSZ_W-1:0]     cfg_wr_data,
    // Input requests.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // seq_number, pkt_handle, zero pad
    input  logic [REQ_W-1:0]       s_tuser,   // req_type
    // Results.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // out_seq_number, out_handle, fill_count, pad
    output logic [STATUS_W-1:0]    m_tuser    // status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > MAXSZ_W) ? CNT_W : MAXSZ_W;

    // Limit register.
    logic [MAXSZ_W-1:0] max_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= MAXSZ_RESET;
        end else if (cfg_wr_en) begin
            max_size_reg <= cfg_wr_data;
        end
    end

    // Input fields.
    logic                   s_xfer;
    req_t                   req;
    logic [SEQ_BITS-1:0]    in_seq;
    logic [HANDLE_BITS-1:0] in_hnd;

    assign s_xfer = s_tvalid && s_tready;
    assign req    = req_t'(s_tuser);
    assign in_seq = s_tdata[SEQ_BITS-1:0];
    assign in_hnd = s_tdata[SEQ_BITS+HANDLE_BITS-1:SEQ_BITS];

    // Cell row wiring.
    logic [DEPTH-1:0]       occ_vec;
    logic [SEQ_BITS-1:0]    seq_a [DEPTH];
    logic [HANDLE_BITS-1:0] hnd_a [DEPTH];
    spb_cell_flag_t         flag_a [DEPTH];
    spb_cell_cmd_t          cmd_a [DEPTH];
    logic [DEPTH-1:0]       ge_vec, eq_vec, first_vec, below_vec, after_vec, push_vec;

    // Fill count.
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full, dup, do_ins, do_push, do_pop;

    assign full = (CMP_W'(count_reg) >= CMP_W'(max_size_reg)) ||
                  (count_reg == CNT_W'(DEPTH));

    // Locate the insert point: the lowest cell that is empty or not smaller.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge_vec[i]   = flag_a[i].ge;
            eq_vec[i]   = flag_a[i].eq;
            push_vec[i] = ((i == 0) ? 1'b1 : occ_vec[(i == 0) ? 0 : i-1]) && !occ_vec[i];
        end
        first_vec = ge_vec & (~ge_vec + DEPTH'(1));
        below_vec = first_vec - DEPTH'(1);
        after_vec = ~(below_vec | first_vec);
    end

    assign dup = |(first_vec & eq_vec);

    // Decode the accepted request.
    always_comb begin
        do_ins  = 1'b0;
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (s_xfer) begin
            unique case (req)
                REQ_INSERT: do_ins  = !full && !dup;
                REQ_PUSH:   do_push = !full;
                REQ_POP:    do_pop  = (count_reg != '0);
                default:    ;
            endcase
        end
    end

    // Per-cell commands.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cmd_a[i].ld_new     = (do_ins && first_vec[i]) || (do_push && push_vec[i]);
            cmd_a[i].shift_up   = do_ins && after_vec[i];
            cmd_a[i].shift_down = do_pop;
        end
    end

    // The row of cells; cell 0 is the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                   up_occ, dn_occ;
        logic [SEQ_BITS-1:0]    up_seq, dn_seq;
        logic [HANDLE_BITS-1:0] up_hnd, dn_hnd;

        if (g == 0) begin : g_head
            assign up_occ = 1'b1;
            assign up_seq = '0;
            assign up_hnd = '0;
        end else begin : g_mid_up
            assign up_occ = occ_vec[g-1];
            assign up_seq = seq_a[g-1];
            assign up_hnd = hnd_a[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign dn_occ = 1'b0;
            assign dn_seq = '0;
            assign dn_hnd = '0;
        end else begin : g_mid_dn
            assign dn_occ = occ_vec[g+1];
            assign dn_seq = seq_a[g+1];
            assign dn_hnd = hnd_a[g+1];
        end

        spb_cell #(
            .SEQ_BITS    (SEQ_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd_a[g]),
            .key_seq (in_seq),
            .key_hnd (in_hnd),
            .up_occ  (up_occ),
            .up_seq  (up_seq),
            .up_hnd  (up_hnd),
            .dn_occ  (dn_occ),
            .dn_seq  (dn_seq),
            .dn_hnd  (dn_hnd),
            .occ     (occ_vec[g]),
            .seq     (seq_a[g]),
            .hnd     (hnd_a[g]),
            .flag    (flag_a[g])
        );
    end

    // Next fill count.
    always_comb begin
        count_next = count_reg;
        priority if (do_ins || do_push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register; the input is taken whenever it is empty or being drained.
    logic                   m_valid_reg;
    status_t                status_reg, status_next;
    logic [SEQ_BITS-1:0]    oseq_reg;
    logic [HANDLE_BITS-1:0] ohnd_reg;
    logic [FILL_W-1:0]      fill_reg;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        status_next = ST_OK;
        unique case (req)
            REQ_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (dup) begin
                    status_next = ST_DUP;
                end
            end
            REQ_PUSH: begin
                if (full) begin
                    status_next = ST_FULL;
                end
            end
            REQ_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            status_reg <= status_next;
            oseq_reg   <= do_pop ? seq_a[0] : '0;
            ohnd_reg   <= do_pop ? hnd_a[0] : '0;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = TDATA_OUT_W'({fill_reg, ohnd_reg, oseq_reg});

    // Checks on the cell row and the fill count.
    `SPB_ASSERT_NOW(a_occ_matches_count, aclk, aresetn,
        1'b1, $countones(occ_vec) == 32'(count_reg))
    `SPB_ASSERT_NOW(a_occ_thermometer, aclk, aresetn,
        1'b1, ((occ_vec + DEPTH'(1)) & occ_vec) == '0)
    `SPB_ASSERT_NEXT(a_pop_decrements, aclk, aresetn,
        s_xfer && (req == REQ_POP) && (count_reg != '0),
        count_reg == $past(count_reg) - CNT_W'(1))
    `SPB_ASSERT_NOW(a_full_only_at_limit, aclk, aresetn,
        m_tvalid && (m_tuser == ST_FULL),
        (CMP_W'(fill_reg) >= CMP_W'(max_size_reg)) || (CNT_W'(fill_reg) == CNT_W'(DEPTH)))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted packet buffer: a scoreboard class predicts
// each transfer's result; plain tasks drive the request and limit ports.
// Depends on spb_pkg and the seqnum_sorted_packet_buffer RTL.
`timescale 1ns / 1ps

module testbench;
    import spb_pkg::*;

    localparam int SEQ_W = SPB_SEQ_BITS;
    localparam int HND_W = SPB_HANDLE_BITS;
    localparam int IN_W  = ((SEQ_W + HND_W + 7) / 8) * 8;
    localparam int OUT_W = ((SEQ_W + HND_W + FILL_W + 7) / 8) * 8;

    // Request code with no defined meaning; the buffer must leave its state alone.
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 170;
    localparam int STALL_CYCLES  = 300;

    typedef struct {
        status_t            status;
        logic [SEQ_W-1:0]   seq;
        logic [HND_W-1:0]   hnd;
        logic [FILL_W-1:0]  fill;
    } buf_result_t;

    // Predicts the buffer's contents and holds the results still owed by the block.
    class spb_scoreboard;
        logic [SEQ_W-1:0]  seq_row[SPB_DEPTH];
        logic [HND_W-1:0]  hnd_row[SPB_DEPTH];
        int unsigned       held;
        logic [MAXSZ_W-1:0] limit;
        buf_result_t       owed_q[$];
        int unsigned       errors;

        function new();
            held   = 0;
            limit  = MAXSZ_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [MAXSZ_W-1:0] value);
            limit = value;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function bit at_capacity();
            int unsigned cap;
            cap = (limit > SPB_DEPTH) ? SPB_DEPTH : limit;
            return held >= cap;
        endfunction

        // Apply one accepted request transfer and queue the result it must produce.
        function void note_request(logic [REQ_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                   logic [HND_W-1:0] hnd);
            buf_result_t want;
            int unsigned pos;
            want.status = ST_OK;
            want.seq    = '0;
            want.hnd    = '0;
            case (kind)
                REQ_INSERT: begin
                    if (at_capacity()) begin
                        want.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held && seq_row[pos] < seq)
                            pos++;
                        // Only the first entry that is not smaller is compared.
                        if (pos < held && seq_row[pos] == seq) begin
                            want.status = ST_DUP;
                        end else begin
                            for (int i = held; i > pos; i--) begin
                                seq_row[i] = seq_row[i-1];
                                hnd_row[i] = hnd_row[i-1];
                            end
                            seq_row[pos] = seq;
                            hnd_row[pos] = hnd;
                            held++;
                        end
                    end
                end
                REQ_PUSH: begin
                    if (at_capacity()) begin
                        want.status = ST_FULL;
                    end else begin
                        seq_row[held] = seq;
                        hnd_row[held] = hnd;
                        held++;
                    end
                end
                REQ_POP: begin
                    if (held == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        want.seq = seq_row[0];
                        want.hnd = hnd_row[0];
                        for (int i = 1; i < held; i++) begin
                            seq_row[i-1] = seq_row[i];
                            hnd_row[i-1] = hnd_row[i];
                        end
                        held--;
                    end
                end
                default: begin
                end
            endcase
            want.fill = held[FILL_W-1:0];
            owed_q.push_back(want);
        endfunction

        // Compare one accepted result transfer with the oldest owed result.
        function void check_result(status_t status, logic [SEQ_W-1:0] seq,
                                   logic [HND_W-1:0] hnd, logic [FILL_W-1:0] fill);
            buf_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d seq %0d handle %0h fill %0d",
                         $time, status, seq, hnd, fill);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (seq !== want.seq) begin
                $display("%0t: out_seq_number mismatch: expected %0d, actual %0d",
                         $time, want.seq, seq);
                errors++;
            end
            if (hnd !== want.hnd) begin
                $display("%0t: out_handle mismatch: expected %0h, actual %0h",
                         $time, want.hnd, hnd);
                errors++;
            end
            if (fill !== want.fill) begin
                $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                         $time, want.fill, fill);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [MAXSZ_W-1:0] cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;   // seq_number, pkt_handle, zero pad
    logic [REQ_W-1:0]   s_tuser;   // req_type
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;   // out_seq_number, out_handle, fill_count, pad
    logic [STATUS_W-1:0] m_tuser;  // status

    spb_scoreboard sb = new();
    bit            tx_idle;
    bit            rx_idle;
    int unsigned   cycles = 0;

    seqnum_sorted_packet_buffer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the buffer takes the transfer.
    // Called and returns at a falling edge.
    task automatic send_request(logic [REQ_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                logic [HND_W-1:0] hnd);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - SEQ_W - HND_W){1'b0}}, hnd, seq};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, seq, hnd);
        @(negedge aclk);
    endtask

    // Change the limit once every owed result has come back.
    task automatic write_limit(logic [MAXSZ_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // Sequence numbers lean toward the extremes and a narrow window that makes duplicates.
    function automatic logic [SEQ_W-1:0] pick_seq();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 6)
            return SEQ_W'($urandom_range(0, 31));
        else
            return SEQ_W'($urandom_range(0, 255));
    endfunction

    // Result side: random tready gaps, two long stalls, and a check of every transfer.
    initial begin
        int gap;
        int got;
        m_tready = 1'b0;
        rx_idle  = 1'b1;
        got      = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (got % 50 == 0)
                rx_idle = ($urandom_range(0, 2) != 0);
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            // Hold off long enough for the buffer to back up and stall its input.
            if (got == 400 || got == 1100)
                gap = STALL_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(status_t'(m_tuser), m_tdata[SEQ_W-1:0],
                            m_tdata[SEQ_W+HND_W-1:SEQ_W],
                            m_tdata[SEQ_W+HND_W+FILL_W-1:SEQ_W+HND_W]);
            got++;
        end
    end

    // Request side: directed cases, then random phases under a range of limits.
    initial begin
        logic [MAXSZ_W-1:0] limits[10];
        logic [REQ_W-1:0]   kind;
        bit                 filling;
        int                 seg_left;
        int                 sent;
        int                 w;

        limits = '{6'd32, 6'd63, 6'd4, 6'd1, 6'd0, 6'd17, 6'd32, 6'd9, 6'd63, 6'd2};
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_idle     = 1'b1;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset limit of one: pop on empty, undefined request, an insert, then two full adds.
        send_request(REQ_POP,    8'd0,   16'h0000);
        send_request(REQ_UNDEF,  8'd77,  16'h1234);
        send_request(REQ_INSERT, 8'h80,  16'hFFFF);
        send_request(REQ_INSERT, 8'h10,  16'h0001);
        send_request(REQ_PUSH,   8'h20,  16'h0002);
        send_request(REQ_POP,    8'd0,   16'h0000);

        // Ordering, duplicates in the middle and at the top, and an out-of-order push
        // hiding a value from the duplicate check.
        write_limit(6'd32);
        send_request(REQ_INSERT, 8'd255, 16'h0000);
        send_request(REQ_INSERT, 8'd0,   16'hFFFF);
        send_request(REQ_INSERT, 8'd100, 16'hA5A5);
        send_request(REQ_INSERT, 8'd100, 16'h1111);
        send_request(REQ_INSERT, 8'd255, 16'h2222);
        send_request(REQ_PUSH,   8'd50,  16'h5A5A);
        send_request(REQ_INSERT, 8'd150, 16'h3333);
        send_request(REQ_INSERT, 8'd50,  16'h4444);
        send_request(REQ_INSERT, 8'd50,  16'h5555);
        send_request(REQ_UNDEF,  8'd255, 16'hFFFF);
        send_request(REQ_POP,    8'd0,   16'h0000);
        send_request(REQ_POP,    8'd0,   16'h0000);

        // A zero limit refuses every add while pops still drain.
        write_limit(6'd0);
        send_request(REQ_INSERT, 8'd7,   16'h0707);
        send_request(REQ_PUSH,   8'd8,   16'h0808);
        send_request(REQ_POP,    8'd0,   16'h0000);

        // Limit below the fill: adds are refused as full while pops bring the count down.
        write_limit(6'd2);
        send_request(REQ_INSERT, 8'd9,   16'h0909);
        send_request(REQ_POP,    8'd0,   16'h0000);
        send_request(REQ_PUSH,   8'd3,   16'h0303);
        send_request(REQ_POP,    8'd0,   16'h0000);

        // Random phases: segments alternate between filling and draining the buffer.
        foreach (limits[p]) begin
            write_limit(limits[p]);
            sent     = 0;
            seg_left = 0;
            filling  = 1'b1;
            while (sent < PHASE_ITEMS) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 60);
                    filling  = ~filling;
                    tx_idle  = ($urandom_range(0, 2) != 0);
                end
                seg_left--;
                w = $urandom_range(0, 99);
                if (w < 3)
                    kind = REQ_UNDEF;
                else if (w < (filling ? 58 : 20))
                    kind = REQ_INSERT;
                else if (w < (filling ? 80 : 30))
                    kind = REQ_PUSH;
                else
                    kind = REQ_POP;
                send_request(kind, pick_seq(), HND_W'($urandom_range(0, 65535)));
                if (kind != REQ_UNDEF)
                    sent++;
            end
        end

        // Drain, then give any stray result time to show up.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
